### hw/rtl/pft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path forwarding table package
// Shared request, status and sequencer codes.
// ----------------------------------------------------------------------------
package pft_pkg;

   typedef enum logic [1:0] {
      ACT_FIND    = 2'd0,
      ACT_INSTALL = 2'd1,
      ACT_REVOKE  = 2'd2,
      ACT_EXPIRE  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_ARG   = 3'd1,
      ST_DENIED    = 3'd2,
      ST_NO_SPACE  = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      FSM_IDLE  = 4'b0001,
      FSM_READ  = 4'b0010,
      FSM_CHECK = 4'b0100,
      FSM_DONE  = 4'b1000
   } fsm_type;

   localparam logic [15:0] NODE_BCAST = 16'hFFFF;

endpackage

### hw/rtl/path_forwarding_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path forwarding table
// Keyed table of path entries serving find, install, revoke and expire.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. The sequencer reads
// one slot from the entry memory per step, a read state then a compare state
// for each slot, and ends in a done state; busy stays high until it is back in
// idle. The result appears for one cycle with rsp_strobe and cannot be stalled.
module path_forwarding_table #(
   parameter int ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [15:0] req_owner_node,
   input  logic [31:0] req_session,
   input  logic [31:0] req_path_number,
   input  logic [15:0] req_dest_node,
   input  logic [15:0] req_hop_node,
   input  logic [7:0]  req_hops_left,
   input  logic [3:0]  req_link_index,
   input  logic        req_has_capability,
   input  logic [7:0]  req_wire_profile,
   input  logic [15:0] req_mtu,
   input  logic [31:0] req_time_ms,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_out_next_hop,
   output logic [7:0]  rsp_out_hops_left,
   output logic [3:0]  rsp_out_link,
   output logic        rsp_out_terminal,
   output logic [7:0]  rsp_out_profile,
   output logic [15:0] rsp_out_mtu,
   output logic [31:0] rsp_out_deadline,
   output logic [4:0]  rsp_expired_count
);

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int EW = 16 + 32 + 32 + 16 + 29 + 24 + 32;

   logic [EW-1:0] mem [ENTRIES];
   logic [ENTRIES-1:0] valid_ff, valid_in;

   pft_pkg::fsm_type state_ff, state_in;
   logic [7:0] hwp_ff;
   logic [IW-1:0] idx_ff, idx_in;
   logic [EW-1:0] rd_ff;
   logic [1:0] act_ff;
   logic [15:0] own_ff, dst_ff;
   logic [31:0] ses_ff, pth_ff, tms_ff;
   logic [28:0] route_ff;
   logic [23:0] cap_ff;
   logic bad_ff;
   logic free_ok_ff, free_ok_in;
   logic [IW-1:0] free_ff, free_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [2:0] st_ff, st_in;
   logic hit_ff, hit_in;
   logic [84:0] hitent_ff, hitent_in;
   logic wr_en;
   logic [IW-1:0] wr_idx;
   logic [EW-1:0] wr_data;
   logic last;
   logic [2:0] done_st;
   logic found;

   logic [15:0] e_own, e_dst;
   logic [31:0] e_ses, e_pth, e_dl, e_diff;
   logic [28:0] e_route;
   logic [23:0] e_cap;
   logic keyhit, term, key_ok, bad;
   logic accept;

   assign accept = start && !busy;
   assign busy = (state_ff != pft_pkg::FSM_IDLE);
   assign csr_ready = 1'b1;
   assign last = (idx_ff == IW'(ENTRIES - 1));
   assign {e_own, e_ses, e_pth, e_dst, e_route, e_cap, e_dl} = rd_ff;
   assign keyhit = valid_ff[idx_ff] && e_own == own_ff && e_ses == ses_ff
      && e_pth == pth_ff;
   assign e_diff = tms_ff - e_dl;

   assign term = (req_hop_node == 16'd0);
   assign key_ok = req_owner_node != 16'd0 && req_owner_node != pft_pkg::NODE_BCAST
      && req_session != 32'd0 && req_path_number != 32'd0
      && req_dest_node != 16'd0 && req_dest_node != pft_pkg::NODE_BCAST;
   always_comb begin
      bad = !key_ok;
      if (req_action == pft_pkg::ACT_INSTALL) begin
         bad = !key_ok || req_time_ms == 32'd0 || (term != (req_hops_left == 8'd0))
            || (term != (req_link_index == 4'd0));
         if (req_has_capability && (term || req_mtu == 16'd0
               || req_wire_profile == 8'd0 || req_wire_profile > hwp_ff)) begin
            bad = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[idx_ff];
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      valid_in = valid_ff;
      free_ok_in = free_ok_ff;
      free_in = free_ff;
      cnt_in = cnt_ff;
      st_in = st_ff;
      hit_in = hit_ff;
      hitent_in = hitent_ff;
      wr_en = 1'b0;
      wr_idx = idx_ff;
      wr_data = {e_own, e_ses, e_pth, e_dst, route_ff, cap_ff, tms_ff};
      unique case (state_ff)
         pft_pkg::FSM_IDLE: begin
            if (accept) begin
               idx_in = '0;
               free_ok_in = 1'b0;
               cnt_in = '0;
               hit_in = 1'b0;
               st_in = pft_pkg::ST_OK;
               state_in = pft_pkg::FSM_READ;
            end
         end
         pft_pkg::FSM_READ: begin
            state_in = pft_pkg::FSM_CHECK;
         end
         pft_pkg::FSM_CHECK: begin
            state_in = pft_pkg::FSM_READ;
            if (last) begin
               state_in = pft_pkg::FSM_DONE;
            end
            unique case (act_ff)
               pft_pkg::ACT_FIND: begin
                  if (!hit_ff && keyhit && e_dst == dst_ff) begin
                     hit_in = 1'b1;
                     hitent_in = {e_route, e_cap, e_dl};
                  end
               end
               pft_pkg::ACT_INSTALL: begin
                  if (!hit_ff && keyhit) begin
                     hit_in = 1'b1;
                     if (e_dst != dst_ff) begin
                        st_in = pft_pkg::ST_DENIED;
                     end else begin
                        wr_en = !bad_ff;
                     end
                  end
                  if (!valid_ff[idx_ff] && !free_ok_ff) begin
                     free_ok_in = 1'b1;
                     free_in = idx_ff;
                  end
               end
               pft_pkg::ACT_REVOKE: begin
                  if (!hit_ff && keyhit && e_dst == dst_ff) begin
                     hit_in = 1'b1;
                     valid_in[idx_ff] = bad_ff ? valid_ff[idx_ff] : 1'b0;
                  end
               end
               pft_pkg::ACT_EXPIRE: begin
                  if (valid_ff[idx_ff] && !e_diff[31]) begin
                     valid_in[idx_ff] = 1'b0;
                     cnt_in = (cnt_ff == 5'd31) ? cnt_ff : cnt_ff + 5'd1;
                  end
               end
               default: ;
            endcase
            idx_in = idx_ff + IW'(1);
         end
         pft_pkg::FSM_DONE: begin
            state_in = pft_pkg::FSM_IDLE;
            idx_in = '0;
            if (act_ff == pft_pkg::ACT_INSTALL && !bad_ff && !hit_ff && free_ok_ff) begin
               wr_en = 1'b1;
               wr_idx = free_ff;
               wr_data = {own_ff, ses_ff, pth_ff, dst_ff, route_ff, cap_ff, tms_ff};
               valid_in[free_ff] = 1'b1;
            end
         end
         default: state_in = pft_pkg::FSM_IDLE;
      endcase
   end

   always_comb begin
      found = 1'b0;
      done_st = pft_pkg::ST_OK;
      unique case (act_ff)
         pft_pkg::ACT_FIND: begin
            if (!bad_ff && hit_ff) begin
               found = 1'b1;
            end else begin
               done_st = pft_pkg::ST_NOT_FOUND;
            end
         end
         pft_pkg::ACT_INSTALL: begin
            if (bad_ff) begin
               done_st = pft_pkg::ST_BAD_ARG;
            end else if (hit_ff) begin
               done_st = st_ff;
            end else if (!free_ok_ff) begin
               done_st = pft_pkg::ST_NO_SPACE;
            end
         end
         pft_pkg::ACT_REVOKE: begin
            if (bad_ff) begin
               done_st = pft_pkg::ST_BAD_ARG;
            end else if (!hit_ff) begin
               done_st = pft_pkg::ST_NOT_FOUND;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pft_pkg::FSM_IDLE;
         valid_ff <= '0;
         hwp_ff <= 8'd3;
         idx_ff <= '0;
         rsp_strobe <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         idx_ff <= idx_in;
         if (csr_valid && csr_ready) begin
            hwp_ff <= csr_data;
         end
         rsp_strobe <= (state_ff == pft_pkg::FSM_DONE);
      end
   end

   always_ff @(posedge clock) begin
      free_ok_ff <= free_ok_in;
      free_ff <= free_in;
      cnt_ff <= cnt_in;
      hit_ff <= hit_in;
      hitent_ff <= hitent_in;
      st_ff <= st_in;
      if (accept) begin
         act_ff <= req_action;
         own_ff <= req_owner_node;
         ses_ff <= req_session;
         pth_ff <= req_path_number;
         dst_ff <= req_dest_node;
         tms_ff <= req_time_ms;
         route_ff <= {term, req_link_index, req_hops_left, req_hop_node};
         cap_ff <= req_has_capability ? {req_mtu, req_wire_profile} : 24'd0;
         bad_ff <= bad;
      end
      if (state_ff == pft_pkg::FSM_DONE) begin
         rsp_status <= done_st;
         rsp_out_next_hop <= found ? hitent_ff[71:56] : 16'd0;
         rsp_out_hops_left <= found ? hitent_ff[79:72] : 8'd0;
         rsp_out_link <= found ? hitent_ff[83:80] : 4'd0;
         rsp_out_terminal <= found ? hitent_ff[84] : 1'b0;
         rsp_out_profile <= found ? hitent_ff[39:32] : 8'd0;
         rsp_out_mtu <= found ? hitent_ff[55:40] : 16'd0;
         rsp_out_deadline <= found ? hitent_ff[31:0] : 32'd0;
         rsp_expired_count <= cnt_ff;
      end
   end

`ifndef NO_ASSERTIONS
   a_strobe_after_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pft_pkg::FSM_DONE) |=> rsp_strobe) else $error("missing strobe");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |=> !(state_ff == pft_pkg::FSM_IDLE && $past(state_ff) == pft_pkg::FSM_READ))
      else $error("bad sequencer step");
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pft_pkg::FSM_IDLE) |-> (idx_ff == '0)) else $error("index not reset");
   a_cnt_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pft_pkg::FSM_READ && idx_ff == '0) |-> (cnt_ff == 5'd0))
      else $error("count not cleared");
`endif

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path forwarding table testbench
// Sends find, install, revoke and expire requests to the table and checks
// every response against a table model kept in the bench. The profile limit
// register is changed between phases, always with the table idle.
// ----------------------------------------------------------------------------
module testbench;

   typedef struct packed {
      pft_pkg::action_type action;
      logic [15:0] owner;
      logic [31:0] session;
      logic [31:0] path;
      logic [15:0] dest;
      logic [15:0] hop;
      logic [7:0]  hops;
      logic [3:0]  link;
      logic        cap;
      logic [7:0]  profile;
      logic [15:0] mtu;
      logic [31:0] time_ms;
   } request_type;

   typedef struct packed {
      pft_pkg::status_type status;
      logic [15:0] fwd_hop;
      logic [7:0]  hops_left;
      logic [3:0]  link;
      logic        terminal;
      logic [7:0]  profile;
      logic [15:0] mtu;
      logic [31:0] deadline;
      logic [4:0]  expired;
   } response_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] owner;
      logic [31:0] session;
      logic [31:0] path;
      logic [15:0] dest;
      logic [15:0] fwd_hop;
      logic [7:0]  hops;
      logic [3:0]  link;
      logic        terminal;
      logic [7:0]  profile;
      logic [15:0] mtu;
      logic [31:0] deadline;
   } entry_type;

   localparam int REQ_BITS = $bits(request_type);

   class route_table_scoreboard;
      entry_type    slots[16];
      logic [7:0]   profile_limit;
      response_type pending[$];
      int           mismatches;

      function new();
         profile_limit = 8'd3;
         mismatches = 0;
         foreach (slots[i]) slots[i] = '0;
      endfunction

      function bit node_ok(logic [15:0] n);
         return n != 16'd0 && n != pft_pkg::NODE_BCAST;
      endfunction

      function bit key_ok(request_type r);
         return node_ok(r.owner) && r.session != 0 && r.path != 0 && node_ok(r.dest);
      endfunction

      function bit key_hits(int i, request_type r);
         return slots[i].valid && slots[i].owner == r.owner &&
                slots[i].session == r.session && slots[i].path == r.path;
      endfunction

      function response_type lookup_result(request_type r);
         response_type res;
         bit           term;
         bit           bad;
         bit           done;
         int           free_slot;
         logic [31:0]  age;
         logic [4:0]   cleared;
         res = '0;
         done = 1'b0;
         free_slot = -1;
         cleared = '0;
         term = (r.hop == 16'd0);
         case (r.action)
            pft_pkg::ACT_FIND: begin
               res.status = pft_pkg::ST_NOT_FOUND;
               if (key_ok(r)) begin
                  for (int i = 0; i < 16; i++) begin
                     if (!done && key_hits(i, r) && slots[i].dest == r.dest) begin
                        done = 1'b1;
                        res.status = pft_pkg::ST_OK;
                        res.fwd_hop = slots[i].fwd_hop;
                        res.hops_left = slots[i].hops;
                        res.link = slots[i].link;
                        res.terminal = slots[i].terminal;
                        res.profile = slots[i].profile;
                        res.mtu = slots[i].mtu;
                        res.deadline = slots[i].deadline;
                     end
                  end
               end
            end
            pft_pkg::ACT_INSTALL: begin
               bad = !key_ok(r) || r.time_ms == 0 ||
                     (term && r.hops != 0) || (!term && r.hops == 0) ||
                     (term && r.link != 0) || (!term && r.link == 0);
               if (r.cap && (term || r.mtu == 0 || r.profile == 0 ||
                             r.profile > profile_limit))
                  bad = 1'b1;
               if (bad) begin
                  res.status = pft_pkg::ST_BAD_ARG;
               end else begin
                  for (int i = 0; i < 16; i++) begin
                     if (!done && key_hits(i, r)) begin
                        done = 1'b1;
                        if (slots[i].dest != r.dest) begin
                           res.status = pft_pkg::ST_DENIED;
                        end else begin
                           res.status = pft_pkg::ST_OK;
                           free_slot = i;
                        end
                     end
                     if (!done && !slots[i].valid && free_slot < 0) free_slot = i;
                  end
                  if (!done && free_slot < 0) begin
                     res.status = pft_pkg::ST_NO_SPACE;
                  end else if (res.status == pft_pkg::ST_OK) begin
                     slots[free_slot].valid = 1'b1;
                     slots[free_slot].owner = r.owner;
                     slots[free_slot].session = r.session;
                     slots[free_slot].path = r.path;
                     slots[free_slot].dest = r.dest;
                     slots[free_slot].fwd_hop = r.hop;
                     slots[free_slot].hops = r.hops;
                     slots[free_slot].link = r.link;
                     slots[free_slot].terminal = term;
                     slots[free_slot].profile = r.cap ? r.profile : 8'd0;
                     slots[free_slot].mtu = r.cap ? r.mtu : 16'd0;
                     slots[free_slot].deadline = r.time_ms;
                  end
               end
            end
            pft_pkg::ACT_REVOKE: begin
               if (!key_ok(r)) begin
                  res.status = pft_pkg::ST_BAD_ARG;
               end else begin
                  res.status = pft_pkg::ST_NOT_FOUND;
                  for (int i = 0; i < 16; i++) begin
                     if (!done && key_hits(i, r) && slots[i].dest == r.dest) begin
                        done = 1'b1;
                        slots[i] = '0;
                        res.status = pft_pkg::ST_OK;
                     end
                  end
               end
            end
            default: begin
               res.status = pft_pkg::ST_OK;
               for (int i = 0; i < 16; i++) begin
                  age = r.time_ms - slots[i].deadline;
                  if (slots[i].valid && age < 32'h8000_0000) begin
                     slots[i] = '0;
                     if (cleared < 5'd31) cleared++;
                  end
               end
               res.expired = cleared;
            end
         endcase
         return res;
      endfunction

      function void note_request(request_type r);
         pending.push_back(lookup_result(r));
      endfunction

      function void check_response(response_type got);
         response_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected response: %p", got);
         end else begin
            want = pending.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_action = '0;
   logic [15:0] req_owner_node = '0;
   logic [31:0] req_session = '0;
   logic [31:0] req_path_number = '0;
   logic [15:0] req_dest_node = '0;
   logic [15:0] req_hop_node = '0;
   logic [7:0]  req_hops_left = '0;
   logic [3:0]  req_link_index = '0;
   logic        req_has_capability = 1'b0;
   logic [7:0]  req_wire_profile = '0;
   logic [15:0] req_mtu = '0;
   logic [31:0] req_time_ms = '0;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data = '0;
   logic        rsp_strobe;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_out_next_hop;
   logic [7:0]  rsp_out_hops_left;
   logic [3:0]  rsp_out_link;
   logic        rsp_out_terminal;
   logic [7:0]  rsp_out_profile;
   logic [15:0] rsp_out_mtu;
   logic [31:0] rsp_out_deadline;
   logic [4:0]  rsp_expired_count;

   route_table_scoreboard table_model = new();
   int          stalled_cycles = 0;
   bit          steady = 1'b0;
   logic [31:0] now_ms;
   logic [15:0] key_owner[20];
   logic [31:0] key_session[20];
   logic [31:0] key_path[20];
   logic [15:0] key_dest[20];

   path_forwarding_table u_dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      request_type  seen;
      response_type got;
      if (!reset && rsp_strobe) begin
         got.status = pft_pkg::status_type'(rsp_status);
         got.fwd_hop = rsp_out_next_hop;
         got.hops_left = rsp_out_hops_left;
         got.link = rsp_out_link;
         got.terminal = rsp_out_terminal;
         got.profile = rsp_out_profile;
         got.mtu = rsp_out_mtu;
         got.deadline = rsp_out_deadline;
         got.expired = rsp_expired_count;
         table_model.check_response(got);
      end
      if (!reset && start && !busy) begin
         seen.action = pft_pkg::action_type'(req_action);
         seen.owner = req_owner_node;
         seen.session = req_session;
         seen.path = req_path_number;
         seen.dest = req_dest_node;
         seen.hop = req_hop_node;
         seen.hops = req_hops_left;
         seen.link = req_link_index;
         seen.cap = req_has_capability;
         seen.profile = req_wire_profile;
         seen.mtu = req_mtu;
         seen.time_ms = req_time_ms;
         table_model.note_request(seen);
      end
      if (!reset && csr_valid && csr_ready) table_model.profile_limit = csr_data;
      if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready) || reset)
         stalled_cycles <= 0;
      else
         stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles == 3000) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic send_request(request_type r);
      req_action <= r.action;
      req_owner_node <= r.owner;
      req_session <= r.session;
      req_path_number <= r.path;
      req_dest_node <= r.dest;
      req_hop_node <= r.hop;
      req_hops_left <= r.hops;
      req_link_index <= r.link;
      req_has_capability <= r.cap;
      req_wire_profile <= r.profile;
      req_mtu <= r.mtu;
      req_time_ms <= r.time_ms;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      if (!steady && $urandom_range(99) < 26) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (table_model.pending.size() != 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_profile_limit(logic [7:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic request_type keyed_install(int k);
      request_type r;
      r = '0;
      r.action = pft_pkg::ACT_INSTALL;
      r.owner = key_owner[k];
      r.session = key_session[k];
      r.path = key_path[k];
      r.dest = key_dest[k];
      r.hop = 16'd7;
      r.hops = 8'd2;
      r.link = 4'd1;
      r.time_ms = now_ms + 32'd100;
      return r;
   endfunction

   function automatic request_type random_request();
      request_type r;
      int          pick;
      pick = $urandom_range(99);
      r = keyed_install($urandom_range(0, 19));
      if (pick < 10) begin
         r = REQ_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
         return r;
      end
      if ($urandom_range(99) < 8) r.dest = 16'($urandom_range(1, 16'hFFFE));
      if ($urandom_range(99) < 3) r.owner = $urandom_range(0, 1) ? 16'd0 : pft_pkg::NODE_BCAST;
      if (pick < 50) begin
         if ($urandom_range(99) < 30) begin
            r.hop = '0;
            r.hops = '0;
            r.link = '0;
         end else begin
            r.hop = 16'($urandom_range(1, 16'hFFFF));
            r.hops = 8'($urandom_range(1, 255));
            r.link = 4'($urandom_range(1, 15));
         end
         if ($urandom_range(99) < 6) r.hops = 8'($urandom);
         if ($urandom_range(99) < 6) r.link = 4'($urandom);
         r.cap = 1'($urandom_range(0, 1));
         r.profile = 8'($urandom_range(1, 8));
         r.mtu = $urandom_range(0, 50) == 0 ? 16'd0 : 16'($urandom_range(1, 16'hFFFF));
         r.time_ms = now_ms + $urandom_range(1, 3000);
         if ($urandom_range(99) < 2) r.time_ms = '0;
      end else if (pick < 72) begin
         r.action = pft_pkg::ACT_FIND;
      end else if (pick < 88) begin
         r.action = pft_pkg::ACT_REVOKE;
      end else begin
         r.action = pft_pkg::ACT_EXPIRE;
         now_ms = now_ms + $urandom_range(0, 1500);
         r.time_ms = now_ms;
      end
      return r;
   endfunction

   initial begin
      request_type r;
      logic [7:0]  limits[4];
      now_ms = $urandom;
      if ($urandom_range(0, 1)) now_ms = 32'hFFFF_F000;
      for (int k = 0; k < 20; k++) begin
         key_owner[k] = 16'($urandom_range(1, 16'hFFFE));
         key_session[k] = $urandom_range(1, 32'hFFFF_FFFF);
         key_path[k] = $urandom_range(1, 32'hFFFF_FFFF);
         key_dest[k] = 16'($urandom_range(1, 16'hFFFE));
      end
      key_owner[0] = 16'd1;
      key_session[0] = 32'hFFFF_FFFF;
      key_path[0] = 32'd1;
      key_dest[0] = 16'hFFFE;
      key_owner[1] = 16'hFFFE;
      key_session[1] = 32'd1;
      key_path[1] = 32'hFFFF_FFFF;
      key_dest[1] = 16'd1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      r = keyed_install(0); r.action = pft_pkg::ACT_FIND; send_request(r);
      r = keyed_install(0); r.hop = '0; r.hops = '0; r.link = '0; send_request(r);
      r.action = pft_pkg::ACT_FIND; send_request(r);
      r = keyed_install(0); r.dest = 16'd9; send_request(r);
      r = keyed_install(0); r.cap = 1'b1; r.profile = 8'd3; r.mtu = 16'hFFFF;
      send_request(r);
      r.action = pft_pkg::ACT_FIND; send_request(r);
      r = keyed_install(1); r.cap = 1'b1; r.profile = 8'd4; r.mtu = 16'd1500;
      send_request(r);
      r.profile = 8'd0; send_request(r);
      r.profile = 8'd1; r.mtu = 16'd0; send_request(r);
      r.mtu = 16'd1; r.hop = '0; r.hops = '0; r.link = '0; send_request(r);
      r = keyed_install(1); r.hops = '0; send_request(r);
      r = keyed_install(1); r.hop = '0; r.hops = '0; r.link = 4'd5; send_request(r);
      r = keyed_install(1); r.time_ms = '0; send_request(r);
      r = keyed_install(1); r.owner = pft_pkg::NODE_BCAST; send_request(r);
      r = keyed_install(1); r.action = pft_pkg::ACT_FIND; r.owner = '0; send_request(r);
      r = keyed_install(1); r.action = pft_pkg::ACT_REVOKE; r.session = '0; send_request(r);
      r = keyed_install(1); r.action = pft_pkg::ACT_REVOKE; send_request(r);
      r = keyed_install(1); r.hop = 16'hFFFF; r.hops = 8'hFF; r.link = 4'hF;
      r.time_ms = 32'hFFFF_FFF0; send_request(r);
      r.action = pft_pkg::ACT_FIND; send_request(r);
      r = '0; r.action = pft_pkg::ACT_EXPIRE; r.time_ms = now_ms + 32'd50; send_request(r);
      r.time_ms = now_ms + 32'd200; send_request(r);
      r = keyed_install(1); r.action = pft_pkg::ACT_REVOKE; send_request(r);
      now_ms = now_ms + 32'd200;

      limits[0] = 8'd255;
      limits[1] = 8'd0;
      limits[2] = 8'($urandom_range(1, 254));
      limits[3] = 8'd3;
      for (int p = 0; p < 4; p++) begin
         write_profile_limit(limits[p]);
         steady = (p == 2);
         for (int n = 0; n < 188; n++) send_request(random_request());
      end
      drain();

      if (table_model.mismatches == 0 && table_model.pending.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
